[hw/rtl/eam_pkg.sv]
package eam_pkg;

  // address width of every range bound
  localparam int unsigned AddrW = 64;

  // default number of processors that can hold a lock
  localparam int unsigned NumCpusDefault = 8;

  // width of the cpu field
  localparam int unsigned CpuW = 3;

  // command codes
  typedef enum logic [1:0] {
    CMD_READ  = 2'd0,
    CMD_WRITE = 2'd1,
    CMD_CLEAR = 2'd2,
    CMD_QUERY = 2'd3
  } cmd_e;

  // one lock range, inclusive ends
  typedef struct packed {
    logic [AddrW-1:0] start;
    logic [AddrW-1:0] last;
  } lock_t;

  // running results of one scan over the lock table
  typedef struct packed {
    logic             blocked;
    logic             own_ok;
    logic             covered;
    logic [AddrW-1:0] win_start;
    logic [AddrW-1:0] win_end;
  } acc_t;

endpackage

[hw/rtl/eam_lock_mem.sv]
module eam_lock_mem #(
  parameter int unsigned Depth = eam_pkg::NumCpusDefault,
  parameter int unsigned IdxW  = 3
) (
  input  logic                clk_i,
  input  logic                wr_en_i,
  input  logic [IdxW-1:0]     wr_addr_i,
  input  eam_pkg::lock_t      wr_data_i,
  input  logic [IdxW-1:0]     rd_addr_i,
  output eam_pkg::lock_t      rd_data_o
);

  eam_pkg::lock_t mem_q [Depth];
  eam_pkg::lock_t rd_data_q;

  // write port
  always_ff @(posedge clk_i) begin
    if (wr_en_i) begin
      mem_q[wr_addr_i] <= wr_data_i;
    end
  end

  // registered read port
  always_ff @(posedge clk_i) begin
    rd_data_q <= mem_q[rd_addr_i];
  end

  assign rd_data_o = rd_data_q;

endmodule

[hw/rtl/eam_scan.sv]
module eam_scan (
  input  eam_pkg::cmd_e                cmd_i,
  input  logic [eam_pkg::AddrW-1:0]    addr_start_i,
  input  logic [eam_pkg::AddrW-1:0]    addr_end_i,
  input  eam_pkg::lock_t               entry_i,
  input  logic                         entry_valid_i,
  input  logic                         is_own_i,
  input  eam_pkg::acc_t                acc_i,
  output eam_pkg::acc_t                acc_o,
  output logic                         clear_o
);

  logic start_le_ae;
  logic as_le_end;
  logic start_le_as;
  logic ae_le_end;
  logic ws_le_end;
  logic start_le_we;
  logic hit;

  // range compares against one lock entry
  assign start_le_ae = entry_i.start <= addr_end_i;
  assign as_le_end   = addr_start_i <= entry_i.last;
  assign start_le_as = entry_i.start <= addr_start_i;
  assign ae_le_end   = addr_end_i <= entry_i.last;
  assign ws_le_end   = acc_i.win_start <= entry_i.last;
  assign start_le_we = entry_i.start <= acc_i.win_end;

  assign hit = entry_valid_i && start_le_ae && as_le_end;

  // writes drop every overlapping lock
  assign clear_o = (cmd_i == eam_pkg::CMD_WRITE) && hit;

  // fold this entry into the running results
  always_comb begin
    acc_o = acc_i;
    if (hit) begin
      acc_o.blocked = 1'b1;
    end
    if (entry_valid_i && is_own_i && start_le_as && ae_le_end) begin
      acc_o.own_ok = 1'b1;
    end
    if (entry_valid_i && start_le_as && as_le_end) begin
      acc_o.covered = 1'b1;
    end
    // lock ends below the query address: pull window start above it
    if (entry_valid_i && !as_le_end && ws_le_end) begin
      acc_o.win_start = entry_i.last + eam_pkg::AddrW'(1);
    end
    // lock starts above the query address: pull window end below it
    if (entry_valid_i && !start_le_as && start_le_we) begin
      acc_o.win_end = entry_i.start - eam_pkg::AddrW'(1);
    end
  end

endmodule

[hw/rtl/exclusive_access_monitor_core.sv]
// channel  | handshake                     | payload
// ---------+-------------------------------+------------------------------------------
// in       | in_valid_i / in_ready_o       | cmd_i cpu_i exclusive_i addr_start_i
//          |                               | addr_end_i window_start_i window_end_i
// out      | out_valid_o / out_ready_i     | proceed_o excl_ok_o direct_blocked_o
//          |                               | window_granted_o out_window_start_o/end_o
//
// the lock table is read one entry per cycle; the result is formed once every
// entry has been scanned.
// one item is in work at a time; the result register lets the next item in
// while the last result still waits. a stalled output holds the block in its
// final step until the result register frees up.
// reset clears all lock valid bits and the control state; no clearing pass.
module exclusive_access_monitor_core #(
  parameter int unsigned NUM_CPUS = eam_pkg::NumCpusDefault
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          in_valid_i,
  output logic                          in_ready_o,
  input  logic [1:0]                    cmd_i,
  input  logic [eam_pkg::CpuW-1:0]      cpu_i,
  input  logic                          exclusive_i,
  input  logic [eam_pkg::AddrW-1:0]     addr_start_i,
  input  logic [eam_pkg::AddrW-1:0]     addr_end_i,
  input  logic [eam_pkg::AddrW-1:0]     window_start_i,
  input  logic [eam_pkg::AddrW-1:0]     window_end_i,
  output logic                          out_valid_o,
  input  logic                          out_ready_i,
  output logic                          proceed_o,
  output logic                          excl_ok_o,
  output logic                          direct_blocked_o,
  output logic                          window_granted_o,
  output logic [eam_pkg::AddrW-1:0]     out_window_start_o,
  output logic [eam_pkg::AddrW-1:0]     out_window_end_o
);

  localparam int unsigned IdxW = (NUM_CPUS > 1) ? $clog2(NUM_CPUS) : 1;
  localparam int unsigned CntW = $clog2(NUM_CPUS + 1);
  localparam int unsigned CmpW = 7;

  typedef enum logic [1:0] {
    S_IDLE,
    S_SCAN,
    S_DONE
  } state_e;

  state_e                    state_q;
  logic [CntW-1:0]           issue_cnt_q;
  logic                      eval_vld_q;
  logic [IdxW-1:0]           eval_idx_q;
  logic [NUM_CPUS-1:0]       lock_valid_q;

  // item registers
  eam_pkg::cmd_e             cmd_q;
  logic [eam_pkg::CpuW-1:0]  cpu_q;
  logic                      excl_q;
  logic [eam_pkg::AddrW-1:0] as_q;
  logic [eam_pkg::AddrW-1:0] ae_q;
  eam_pkg::acc_t             acc_q;
  eam_pkg::acc_t             acc_d;

  // result registers
  logic                      out_valid_q;
  logic                      proceed_q;
  logic                      excl_ok_q;
  logic                      blocked_q;
  logic                      granted_q;
  logic [eam_pkg::AddrW-1:0] ows_q;
  logic [eam_pkg::AddrW-1:0] owe_q;
  logic                      proceed_d;
  logic                      excl_ok_d;
  logic                      blocked_d;
  logic                      granted_d;
  logic [eam_pkg::AddrW-1:0] ows_d;
  logic [eam_pkg::AddrW-1:0] owe_d;

  logic                      in_fire;
  logic                      issue;
  logic                      last_eval;
  logic                      load_out;
  logic                      cpu_ok;
  logic [IdxW-1:0]           cpu_idx;
  logic                      is_own;
  logic                      scan_clear;
  logic                      lock_set;
  logic                      lock_drop;
  logic                      mem_we;
  eam_pkg::lock_t            rd_data;
  eam_pkg::lock_t            wr_data;

  assign in_ready_o = (state_q == S_IDLE);
  assign in_fire    = in_valid_i && in_ready_o;
  assign issue      = (state_q == S_SCAN) && (issue_cnt_q < CntW'(NUM_CPUS));
  assign last_eval  = eval_vld_q && (eval_idx_q == IdxW'(NUM_CPUS - 1));
  assign load_out   = (state_q == S_DONE) && (!out_valid_q || out_ready_i);

  // processor numbers beyond the table own no lock
  assign cpu_ok  = CmpW'(cpu_q) < CmpW'(NUM_CPUS);
  assign cpu_idx = IdxW'(cpu_q);
  assign is_own  = cpu_ok && (eval_idx_q == cpu_idx);

  // exclusive read installs the new lock at the end of the item
  assign mem_we        = load_out && lock_set;
  assign wr_data.start = as_q;
  assign wr_data.last  = ae_q;

  eam_lock_mem #(
    .Depth (NUM_CPUS),
    .IdxW  (IdxW)
  ) u_lock_mem (
    .clk_i     (clk_i),
    .wr_en_i   (mem_we),
    .wr_addr_i (cpu_idx),
    .wr_data_i (wr_data),
    .rd_addr_i (issue_cnt_q[IdxW-1:0]),
    .rd_data_o (rd_data)
  );

  eam_scan u_scan (
    .cmd_i         (cmd_q),
    .addr_start_i  (as_q),
    .addr_end_i    (ae_q),
    .entry_i       (rd_data),
    .entry_valid_i (lock_valid_q[eval_idx_q]),
    .is_own_i      (is_own),
    .acc_i         (acc_q),
    .acc_o         (acc_d),
    .clear_o       (scan_clear)
  );

  // result fields and lock valid update for the item in hand
  always_comb begin
    proceed_d = 1'b1;
    excl_ok_d = 1'b0;
    blocked_d = 1'b0;
    granted_d = 1'b0;
    ows_d     = '0;
    owe_d     = '0;
    lock_set  = 1'b0;
    lock_drop = 1'b0;
    case (cmd_q)
      eam_pkg::CMD_READ: begin
        blocked_d = acc_q.blocked;
        excl_ok_d = excl_q;
        lock_set  = excl_q && cpu_ok;
      end
      eam_pkg::CMD_WRITE: begin
        blocked_d = acc_q.blocked;
        if (excl_q) begin
          excl_ok_d = acc_q.own_ok;
          proceed_d = acc_q.own_ok;
        end
      end
      eam_pkg::CMD_CLEAR: begin
        lock_drop = cpu_ok;
      end
      eam_pkg::CMD_QUERY: begin
        if (acc_q.covered) begin
          owe_d = '1;
        end else begin
          granted_d = 1'b1;
          ows_d     = acc_q.win_start;
          owe_d     = acc_q.win_end;
        end
      end
      default: begin
        proceed_d = 1'b1;
      end
    endcase
  end

  // item capture and scan accumulators
  always_ff @(posedge clk_i) begin
    if (in_fire) begin
      cmd_q           <= eam_pkg::cmd_e'(cmd_i);
      cpu_q           <= cpu_i;
      excl_q          <= exclusive_i;
      as_q            <= addr_start_i;
      ae_q            <= addr_end_i;
      acc_q.blocked   <= 1'b0;
      acc_q.own_ok    <= 1'b0;
      acc_q.covered   <= 1'b0;
      acc_q.win_start <= window_start_i;
      acc_q.win_end   <= window_end_i;
    end else if (eval_vld_q) begin
      acc_q <= acc_d;
    end
  end

  // sequencer, lock valid bits and result register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q      <= S_IDLE;
      issue_cnt_q  <= '0;
      eval_vld_q   <= 1'b0;
      eval_idx_q   <= '0;
      lock_valid_q <= '0;
      out_valid_q  <= 1'b0;
      proceed_q    <= 1'b0;
      excl_ok_q    <= 1'b0;
      blocked_q    <= 1'b0;
      granted_q    <= 1'b0;
      ows_q        <= '0;
      owe_q        <= '0;
    end else begin
      // result valid: set on load, cleared once taken
      if (load_out) begin
        out_valid_q <= 1'b1;
      end else if (out_valid_q && out_ready_i) begin
        out_valid_q <= 1'b0;
      end

      // read pipeline: data for the issued index arrives next cycle
      eval_vld_q <= issue;
      if (issue) begin
        eval_idx_q  <= issue_cnt_q[IdxW-1:0];
        issue_cnt_q <= issue_cnt_q + CntW'(1);
      end

      // writes break overlapping locks as they are scanned
      if (eval_vld_q && scan_clear) begin
        lock_valid_q[eval_idx_q] <= 1'b0;
      end

      case (state_q)
        S_IDLE: begin
          if (in_fire) begin
            issue_cnt_q <= '0;
            state_q     <= S_SCAN;
          end
        end
        S_SCAN: begin
          if (last_eval) begin
            state_q <= S_DONE;
          end
        end
        S_DONE: begin
          if (load_out) begin
            proceed_q <= proceed_d;
            excl_ok_q <= excl_ok_d;
            blocked_q <= blocked_d;
            granted_q <= granted_d;
            ows_q     <= ows_d;
            owe_q     <= owe_d;
            if (lock_set) begin
              lock_valid_q[cpu_idx] <= 1'b1;
            end else if (lock_drop) begin
              lock_valid_q[cpu_idx] <= 1'b0;
            end
            state_q <= S_IDLE;
          end
        end
        default: begin
          state_q <= S_IDLE;
        end
      endcase
    end
  end

  assign out_valid_o        = out_valid_q;
  assign proceed_o          = proceed_q;
  assign excl_ok_o          = excl_ok_q;
  assign direct_blocked_o   = blocked_q;
  assign window_granted_o   = granted_q;
  assign out_window_start_o = ows_q;
  assign out_window_end_o   = owe_q;

endmodule

[hw/rtl/eam_checker.sv]
module eam_checker (
  input logic                          clk_i,
  input logic                          rst_ni,
  input logic                          in_valid_i,
  input logic                          in_ready_o,
  input logic                          out_valid_o,
  input logic                          out_ready_i,
  input logic                          proceed_o,
  input logic                          excl_ok_o,
  input logic                          direct_blocked_o,
  input logic                          window_granted_o,
  input logic [eam_pkg::AddrW-1:0]     out_window_start_o,
  input logic [eam_pkg::AddrW-1:0]     out_window_end_o
);

  // a stalled result holds its fields
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_ready_i |=> out_valid_o && $stable(proceed_o) && $stable(excl_ok_o)
      && $stable(direct_blocked_o) && $stable(window_granted_o)
      && $stable(out_window_start_o) && $stable(out_window_end_o))
    else $error("result changed while stalled");

  // one item at a time: intake closes right after an accept
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && in_ready_o |=> !in_ready_o)
    else $error("intake stayed open after accept");

  // a granted window comes only from a query
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && window_granted_o |-> proceed_o && !excl_ok_o && !direct_blocked_o)
    else $error("granted window with access status");

  // a refused access is never an exclusive success nor a window
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !proceed_o |-> !excl_ok_o && !window_granted_o
      && (out_window_start_o == '0) && (out_window_end_o == '0))
    else $error("failed exclusive write with stray fields");

endmodule

bind exclusive_access_monitor_core eam_checker u_eam_checker (.*);

[bench/testbench.sv]
module testbench;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int unsigned NCpu = eam_pkg::NumCpusDefault;
  localparam int unsigned ClkPeriod = 10;
  localparam int unsigned RandomItems = 1330;
  localparam int unsigned DrainAt = 700;
  localparam int unsigned StallAt = 400;
  localparam int unsigned StallLen = 300;
  localparam int unsigned QuietLo = 900;
  localparam int unsigned QuietHi = 1100;
  localparam int unsigned IdleLimit = 4000;
  localparam int unsigned Settle = NCpu + 3 + 10;

  typedef logic [eam_pkg::AddrW-1:0] addr_t;
  localparam addr_t AllOnes = '1;

  // one access or query as offered on the input channel
  typedef struct {
    eam_pkg::cmd_e            cmd;
    logic [eam_pkg::CpuW-1:0] cpu;
    logic                     excl;
    addr_t                    as;
    addr_t                    ae;
    addr_t                    ws;
    addr_t                    we;
    bit                       hold_for_drain;
  } access_t;

  // the answer the monitor gives for one item
  typedef struct packed {
    logic  proceed;
    logic  excl_ok;
    logic  blocked;
    logic  granted;
    addr_t win_lo;
    addr_t win_hi;
  } outcome_t;

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;
  logic in_valid_i = 1'b0;
  logic in_ready_o;
  logic [1:0] cmd_i = '0;
  logic [eam_pkg::CpuW-1:0] cpu_i = '0;
  logic exclusive_i = 1'b0;
  addr_t addr_start_i = '0;
  addr_t addr_end_i = '0;
  addr_t window_start_i = '0;
  addr_t window_end_i = '0;
  logic out_valid_o;
  logic out_ready_i = 1'b0;
  logic proceed_o;
  logic excl_ok_o;
  logic direct_blocked_o;
  logic window_granted_o;
  addr_t out_window_start_o;
  addr_t out_window_end_o;

  exclusive_access_monitor_core dut (
    .clk_i             (clk_i),
    .rst_ni            (rst_ni),
    .in_valid_i        (in_valid_i),
    .in_ready_o        (in_ready_o),
    .cmd_i             (cmd_i),
    .cpu_i             (cpu_i),
    .exclusive_i       (exclusive_i),
    .addr_start_i      (addr_start_i),
    .addr_end_i        (addr_end_i),
    .window_start_i    (window_start_i),
    .window_end_i      (window_end_i),
    .out_valid_o       (out_valid_o),
    .out_ready_i       (out_ready_i),
    .proceed_o         (proceed_o),
    .excl_ok_o         (excl_ok_o),
    .direct_blocked_o  (direct_blocked_o),
    .window_granted_o  (window_granted_o),
    .out_window_start_o(out_window_start_o),
    .out_window_end_o  (out_window_end_o)
  );

  always #(ClkPeriod / 2) clk_i = ~clk_i;

  // lock table as the bench sees it
  bit    lock_on [NCpu];
  addr_t lock_lo [NCpu];
  addr_t lock_hi [NCpu];

  access_t  access_q[$];
  outcome_t outcome_q[$];
  access_t  offered;
  int unsigned sent_cnt = 0;
  int unsigned seen_cnt = 0;
  int unsigned err_cnt = 0;
  int unsigned quiet_cycles = 0;
  int unsigned stall_left = 0;
  bit stall_done = 1'b0;

  // apply one item to the lock table and work out its answer
  function automatic outcome_t resolve_access(input access_t a);
    outcome_t r;
    bit hit;
    r = '0;
    r.proceed = 1'b1;
    hit = 1'b0;
    case (a.cmd)
      eam_pkg::CMD_READ, eam_pkg::CMD_WRITE: begin
        for (int i = 0; i < NCpu; i++)
          if (lock_on[i] && lock_lo[i] <= a.ae && a.as <= lock_hi[i]) r.blocked = 1'b1;
        if (a.excl) begin
          if (a.cmd == eam_pkg::CMD_READ) begin
            if (a.cpu < NCpu) begin
              lock_on[a.cpu] = 1'b1;
              lock_lo[a.cpu] = a.as;
              lock_hi[a.cpu] = a.ae;
            end
            r.excl_ok = 1'b1;
          end else begin
            r.excl_ok = (a.cpu < NCpu) && lock_on[a.cpu] &&
                        lock_lo[a.cpu] <= a.as && a.ae <= lock_hi[a.cpu];
          end
          r.proceed = r.excl_ok;
        end
        // any write breaks every lock it touches
        if (a.cmd == eam_pkg::CMD_WRITE)
          for (int i = 0; i < NCpu; i++)
            if (lock_on[i] && lock_lo[i] <= a.ae && a.as <= lock_hi[i]) lock_on[i] = 1'b0;
      end
      eam_pkg::CMD_CLEAR: begin
        if (a.cpu < NCpu) lock_on[a.cpu] = 1'b0;
      end
      default: begin
        for (int i = 0; i < NCpu; i++)
          if (lock_on[i] && lock_lo[i] <= a.as && a.as <= lock_hi[i]) hit = 1'b1;
        if (hit) begin
          r.win_lo = '0;
          r.win_hi = AllOnes;
        end else begin
          r.granted = 1'b1;
          r.win_lo = a.ws;
          r.win_hi = a.we;
          // clip around the nearest locks below and above the address
          for (int i = 0; i < NCpu; i++) begin
            if (lock_on[i]) begin
              if (lock_hi[i] < a.as && r.win_lo <= lock_hi[i]) r.win_lo = lock_hi[i] + 1'b1;
              if (lock_lo[i] > a.as && r.win_hi >= lock_lo[i]) r.win_hi = lock_lo[i] - 1'b1;
            end
          end
        end
      end
    endcase
    return r;
  endfunction

  function automatic access_t mk(input eam_pkg::cmd_e cmd, input int unsigned cpu,
                                 input bit excl, input addr_t as, input addr_t ae,
                                 input addr_t ws, input addr_t we);
    access_t a;
    a.cmd = cmd;
    a.cpu = cpu[eam_pkg::CpuW-1:0];
    a.excl = excl;
    a.as = as;
    a.ae = ae;
    a.ws = ws;
    a.we = we;
    a.hold_for_drain = 1'b0;
    return a;
  endfunction

  // append one item to the pending list
  task automatic queue_item(input access_t a);
    access_q.insert(access_q.size(), a);
  endtask

  function automatic addr_t rand_word();
    return {$urandom, $urandom};
  endfunction

  // mostly a crowded low region so locks collide, some near the top, some anywhere
  function automatic addr_t pick_addr();
    int unsigned r;
    r = $urandom_range(99);
    if (r < 75) return addr_t'($urandom_range(2047));
    if (r < 85) return AllOnes - addr_t'($urandom_range(2047));
    return rand_word();
  endfunction

  function automatic addr_t pick_end(input addr_t s);
    if ($urandom_range(9) != 0) return s + addr_t'($urandom_range(127));
    return pick_addr();
  endfunction

  // any command with random content
  function automatic access_t noise_item();
    access_t a;
    addr_t s;
    int unsigned r;
    s = pick_addr();
    a = mk(eam_pkg::cmd_e'($urandom_range(3)), $urandom_range(NCpu - 1),
           1'($urandom_range(1)), s, pick_end(s), rand_word(), rand_word());
    r = $urandom_range(9);
    if (a.cmd == eam_pkg::CMD_QUERY && r < 6) begin
      a.ws = s - addr_t'($urandom_range(1023));
      a.we = s + addr_t'($urandom_range(1023));
    end else if (a.cmd == eam_pkg::CMD_QUERY && r < 8) begin
      a.ws = '0;
      a.we = AllOnes;
    end
    return a;
  endfunction

  task automatic compare_field(input string what, input addr_t want, input addr_t got);
    if (got !== want) begin
      err_cnt++;
      $display("%0t: %s mismatch: expected %h, got %h", $time, what, want, got);
    end
  endtask

  // driver: offers queued items, records the answer of each accepted one
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_i <= 1'b0;
      cmd_i <= eam_pkg::CMD_READ;
      cpu_i <= '0;
      exclusive_i <= 1'b0;
      addr_start_i <= '0;
      addr_end_i <= '0;
      window_start_i <= '0;
      window_end_i <= '0;
    end else begin
      if (in_valid_i && in_ready_o) begin
        outcome_q.insert(outcome_q.size(), resolve_access(offered));
        sent_cnt++;
      end
      if (!in_valid_i || in_ready_o) begin
        if (access_q.size() > 0 &&
            !(access_q[0].hold_for_drain && seen_cnt != sent_cnt) &&
            ((sent_cnt >= QuietLo && sent_cnt < QuietHi) || $urandom_range(99) >= 20)) begin
          offered = access_q.pop_front();
          cmd_i <= offered.cmd;
          cpu_i <= offered.cpu;
          exclusive_i <= offered.excl;
          addr_start_i <= offered.as;
          addr_end_i <= offered.ae;
          window_start_i <= offered.ws;
          window_end_i <= offered.we;
          in_valid_i <= 1'b1;
        end else begin
          in_valid_i <= 1'b0;
        end
      end
    end
  end

  // monitor: checks each answer against the oldest expectation
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_ready_i <= 1'b0;
      seen_cnt <= 0;
    end else begin
      if (out_valid_o && out_ready_i) begin
        if (outcome_q.size() == 0) begin
          err_cnt++;
          $display("%0t: unexpected result: expected none, got proceed %b window %h..%h",
                   $time, proceed_o, out_window_start_o, out_window_end_o);
        end else begin
          outcome_t want;
          want = outcome_q.pop_front();
          compare_field("proceed", addr_t'(want.proceed), addr_t'(proceed_o));
          compare_field("excl_ok", addr_t'(want.excl_ok), addr_t'(excl_ok_o));
          compare_field("direct_blocked", addr_t'(want.blocked), addr_t'(direct_blocked_o));
          compare_field("window_granted", addr_t'(want.granted), addr_t'(window_granted_o));
          compare_field("out_window_start", want.win_lo, out_window_start_o);
          compare_field("out_window_end", want.win_hi, out_window_end_o);
        end
        seen_cnt <= seen_cnt + 1;
      end
      // one long hold-off so the block backs up into its input
      if (!stall_done && seen_cnt == StallAt) begin
        stall_done = 1'b1;
        stall_left = StallLen;
      end
      if (stall_left > 0) begin
        stall_left--;
        out_ready_i <= 1'b0;
      end else begin
        out_ready_i <= (seen_cnt >= QuietLo && seen_cnt < QuietHi) || $urandom_range(99) >= 20;
      end
    end
  end

  // watchdog on cycles with no handshake at all
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if ((in_valid_i && in_ready_o) || (out_valid_o && out_ready_i)) quiet_cycles <= 0;
      else quiet_cycles <= quiet_cycles + 1;
      if (quiet_cycles >= IdleLimit) begin
        $display("DONE: errors detected");
        $finish;
      end
    end
  end

  initial begin
    addr_t s, e, s2, e2;
    int unsigned c;
    int unsigned r;

    // every cpu takes a lock first so the whole table is written
    queue_item(mk(eam_pkg::CMD_READ, 0, 1, '0, 'h0ff, '0, '0));
    for (int i = 1; i < NCpu - 1; i++)
      queue_item(mk(eam_pkg::CMD_READ, i, 1, addr_t'(i * 'h1000),
                    addr_t'(i * 'h1000 + 'hff), '0, '0));
    queue_item(mk(eam_pkg::CMD_READ, NCpu - 1, 1, AllOnes - 'hff, AllOnes, AllOnes,
                  AllOnes));
    // window between two locks clipped on both sides, covered address, window untouched
    queue_item(mk(eam_pkg::CMD_QUERY, 0, 0, 'h1800, '0, '0, AllOnes));
    queue_item(mk(eam_pkg::CMD_QUERY, 3, 0, 'h1050, '0, '0, AllOnes));
    queue_item(mk(eam_pkg::CMD_QUERY, 5, 1, 'h1800, '0, 'h1900, 'h1a00));
    // plain read overlapping another cpu's lock
    queue_item(mk(eam_pkg::CMD_READ, 3, 0, 'h20ff, 'h2100, '0, '0));
    // exclusive write inside own lock, then again with the lock gone
    queue_item(mk(eam_pkg::CMD_WRITE, 1, 1, 'h1010, 'h10ff, '0, '0));
    queue_item(mk(eam_pkg::CMD_WRITE, 1, 1, 'h1010, 'h10ff, '0, '0));
    // exclusive write sticking out of its lock, still breaks it
    queue_item(mk(eam_pkg::CMD_WRITE, 2, 1, 'h20f0, 'h2100, '0, '0));
    // plain write breaking a foreign lock
    queue_item(mk(eam_pkg::CMD_WRITE, 0, 0, 'h3000, 'h3000, '0, '0));
    queue_item(mk(eam_pkg::CMD_CLEAR, 4, 0, '0, '0, '0, '0));
    queue_item(mk(eam_pkg::CMD_CLEAR, 4, 1, AllOnes, AllOnes, AllOnes, AllOnes));
    // queries at both ends of the address space
    queue_item(mk(eam_pkg::CMD_QUERY, 7, 0, AllOnes, AllOnes, '0, AllOnes));
    queue_item(mk(eam_pkg::CMD_QUERY, 0, 0, '0, '0, '0, AllOnes));
    // lock with start above end, then a query that falls in its gap
    queue_item(mk(eam_pkg::CMD_READ, 5, 1, 'h5200, 'h5100, '0, '0));
    queue_item(mk(eam_pkg::CMD_QUERY, 6, 0, 'h5180, '0, '0, AllOnes));
    // window with start above end
    queue_item(mk(eam_pkg::CMD_QUERY, 2, 0, 'h8000, '0, 'h9000, 'h7000));
    // full-range read, then full-range write dropping every lock
    queue_item(mk(eam_pkg::CMD_READ, 7, 0, '0, AllOnes, AllOnes, AllOnes));
    queue_item(mk(eam_pkg::CMD_WRITE, 6, 0, '0, AllOnes, '0, '0));
    queue_item(mk(eam_pkg::CMD_QUERY, 1, 0, 'h1800, AllOnes, '0, AllOnes));

    // mostly load/store exclusive pairs with traffic in between
    for (int n = 0; n < RandomItems; ) begin
      r = $urandom_range(99);
      if (r < 45) begin
        c = $urandom_range(NCpu - 1);
        s = pick_addr();
        e = pick_end(s);
        queue_item(mk(eam_pkg::CMD_READ, c, 1, s, e, rand_word(), rand_word()));
        n++;
        repeat ($urandom_range(3)) begin
          queue_item(noise_item());
          n++;
        end
        if ($urandom_range(3) != 0) begin
          s2 = s + addr_t'($urandom_range(7));
          e2 = e - addr_t'($urandom_range(7));
        end else begin
          s2 = pick_addr();
          e2 = pick_end(s2);
        end
        queue_item(mk(eam_pkg::CMD_WRITE, c, $urandom_range(9) != 0, s2, e2,
                      rand_word(), rand_word()));
        n++;
      end else begin
        queue_item(noise_item());
        n++;
      end
    end
    // the sender waits here until every answer is in
    access_q[DrainAt].hold_for_drain = 1'b1;

    repeat (2) @(posedge clk_i);
    rst_ni <= 1'b1;

    while (access_q.size() != 0 || in_valid_i) @(posedge clk_i);
    while (seen_cnt != sent_cnt) @(posedge clk_i);
    repeat (Settle) @(posedge clk_i);
    if (outcome_q.size() != 0) begin
      err_cnt++;
      $display("%0t: results missing: expected %0d more, got none", $time, outcome_q.size());
    end
    if (err_cnt == 0) begin
      $display("DONE: 0 errors");
    end else begin
      $display("DONE: errors detected");
    end
    $finish;
  end

endmodule
